>>> hdl/lz4_block_decompressor_top_assert.svh
// ---------------------------------------------------------------------------
// LZ4 block decompressor assertion macros
// Shared concurrent assertion macros for the decompressor RTL.
// ---------------------------------------------------------------------------
`ifndef LZ4_BLOCK_DECOMPRESSOR_TOP_ASSERT_SVH
`define LZ4_BLOCK_DECOMPRESSOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LZ4_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LZ4_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LZ4_ASSERT_IMP(label, clk, rst, ante, cons)
`define LZ4_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hdl/lz4_pkg.sv
// ---------------------------------------------------------------------------
// LZ4 decompressor package
// Shared types and constants of the LZ4 block decompressor.
// ---------------------------------------------------------------------------
package lz4_pkg;
  localparam int PosW = 26;
  localparam int HistAw = 16;
  localparam int QDepth = 4;
  localparam int QAw = 2;
  localparam logic [PosW-1:0] LenMax = '1;

  localparam logic [1:0] StRun = 2'd0;
  localparam logic [1:0] StOk = 2'd1;
  localparam logic [1:0] StErr = 2'd2;

  localparam logic [1:0] RegSize = 2'd0;
  localparam logic [1:0] RegTgtEn = 2'd1;
  localparam logic [1:0] RegTgtPos = 2'd2;

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic            out_valid;
    logic [7:0]      out_byte;
    logic            copy_pending;
    logic            done_res;
    logic [1:0]      status;
    logic            literal_found;
    logic [PosW-1:0] literal_pos;
  } out_item_t;

  typedef struct packed {
    logic [PosW-1:0] expected_out_size;
    logic            target_enable;
    logic [24:0]     target_pos;
  } cfg_t;

  // Work handed from the parser to the output stage.
  typedef struct packed {
    logic            wr;       // output byte written to history
    logic            rd;       // byte comes from history
    logic [7:0]      lit;
    logic [HistAw-1:0] addr;   // write address
    logic [HistAw-1:0] raddr;  // read address for a copy
    logic            copy_pending;
    logic            done_res;
    logic [1:0]      status;
    logic            literal_found;
    logic [PosW-1:0] literal_pos;
  } work_t;
endpackage

>>> hdl/lz4_parse.sv
// ---------------------------------------------------------------------------
// LZ4 parser
// Front part: accepts requests and walks the sequence state, one per cycle while take is high.
// ---------------------------------------------------------------------------
`include "lz4_block_decompressor_top_assert.svh"
module lz4_parse import lz4_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     take,
  input  in_item_t item,
  output work_t    work
);
  typedef enum logic [7:0] {
    PH_TOKEN = 8'b00000001, PH_LIT_EXT = 8'b00000010, PH_LITERALS = 8'b00000100,
    PH_OFF_LO = 8'b00001000, PH_OFF_HI = 8'b00010000, PH_MATCH_EXT = 8'b00100000,
    PH_COPY = 8'b01000000, PH_DONE = 8'b10000000
  } phase_t;

  phase_t phase, phase_next;
  logic [3:0] nib, nib_next;
  logic [PosW-1:0] lrem, lrem_next, mrem, mrem_next, spos, spos_next;
  logic [PosW-1:0] opos, opos_next, fpos, fpos_next;
  logic [15:0] mdist, mdist_next;
  logic fflag, fflag_next, eac, eac_next;
  logic [1:0] st, st_next;
  logic [PosW-1:0] room, sum_in, len_sum, mlen;
  logic [PosW:0] raw_sum, raw_m;
  logic size_ok;

  assign room = (cfg.expected_out_size > opos) ? cfg.expected_out_size - opos : '0;
  assign sum_in = (phase == PH_LIT_EXT) ? lrem : mrem;
  assign raw_sum = {1'b0, sum_in} + {{(PosW-7){1'b0}}, item.in_byte};
  assign len_sum = raw_sum[PosW] ? LenMax : raw_sum[PosW-1:0];
  assign size_ok = (opos == cfg.expected_out_size);

  always_comb begin
    logic [PosW-1:0] mbase;
    logic [15:0] d;
    phase_next = phase; nib_next = nib; lrem_next = lrem; mrem_next = mrem;
    spos_next = spos; opos_next = opos; fpos_next = fpos; mdist_next = mdist;
    fflag_next = fflag; eac_next = eac; st_next = st;
    work = '0;
    work.addr = opos[HistAw-1:0];
    work.raddr = opos[HistAw-1:0] - mdist;
    work.lit = item.in_byte;
    mbase = '0; d = mdist; raw_m = '0; mlen = '0;
    if (take && phase != PH_DONE) begin
      if (item.req_type) begin
        if (phase == PH_COPY) begin
          work.wr = 1'b1; work.rd = 1'b1;
          opos_next = opos + 1'b1;
          mrem_next = mrem - 1'b1;
          if (mrem == {{(PosW-1){1'b0}}, 1'b1}) begin
            if (eac) begin
              phase_next = PH_DONE;
              st_next = (opos_next == cfg.expected_out_size) ? StOk : StErr;
            end else begin
              phase_next = PH_TOKEN;
            end
          end
        end
      end else begin
        spos_next = spos + 1'b1;
        case (phase)
          PH_TOKEN: begin
            nib_next = item.in_byte[3:0];
            if (item.in_byte[7:4] == 4'hf) begin
              lrem_next = PosW'(15);
              if (item.in_last) begin
                phase_next = PH_DONE; st_next = StErr;
              end else begin
                phase_next = PH_LIT_EXT;
              end
            end else if (PosW'(item.in_byte[7:4]) > room) begin
              phase_next = PH_DONE; st_next = StErr;
            end else if (item.in_byte[7:4] == 4'h0) begin
              lrem_next = '0;
              if (item.in_last) begin
                phase_next = PH_DONE; st_next = size_ok ? StOk : StErr;
              end else begin
                phase_next = PH_OFF_LO;
              end
            end else if (item.in_last) begin
              phase_next = PH_DONE; st_next = StErr;
            end else begin
              lrem_next = PosW'(item.in_byte[7:4]);
              phase_next = PH_LITERALS;
            end
          end
          PH_LIT_EXT: begin
            lrem_next = len_sum;
            if (item.in_last) begin
              phase_next = PH_DONE; st_next = StErr;
            end else if (item.in_byte != 8'hff) begin
              if (len_sum > room) begin
                phase_next = PH_DONE; st_next = StErr;
              end else begin
                phase_next = PH_LITERALS;
              end
            end
          end
          PH_LITERALS: begin
            if (cfg.target_enable && opos == {1'b0, cfg.target_pos}) begin
              fflag_next = 1'b1; fpos_next = spos;
            end
            work.wr = 1'b1;
            opos_next = opos + 1'b1;
            lrem_next = lrem - 1'b1;
            if (lrem == {{(PosW-1){1'b0}}, 1'b1}) begin
              if (item.in_last) begin
                phase_next = PH_DONE;
                st_next = (opos_next == cfg.expected_out_size) ? StOk : StErr;
              end else begin
                phase_next = PH_OFF_LO;
              end
            end else if (item.in_last) begin
              phase_next = PH_DONE; st_next = StErr;
            end
          end
          PH_OFF_LO: begin
            mdist_next = {8'h00, item.in_byte};
            if (item.in_last) begin
              phase_next = PH_DONE; st_next = StErr;
            end else begin
              phase_next = PH_OFF_HI;
            end
          end
          PH_OFF_HI, PH_MATCH_EXT: begin
            d = (phase == PH_OFF_HI) ? {item.in_byte, mdist[7:0]} : mdist;
            mdist_next = d;
            if (phase == PH_OFF_HI && nib == 4'hf) begin
              mrem_next = PosW'(15);
              if (item.in_last) begin
                phase_next = PH_DONE; st_next = StErr;
              end else begin
                phase_next = PH_MATCH_EXT;
              end
            end else if (phase == PH_MATCH_EXT && item.in_byte == 8'hff) begin
              mrem_next = len_sum;
              if (item.in_last) begin
                phase_next = PH_DONE; st_next = StErr;
              end
            end else begin
              mbase = (phase == PH_OFF_HI) ? PosW'(nib) : len_sum;
              raw_m = {1'b0, mbase} + (PosW+1)'(4);
              mlen = raw_m[PosW] ? LenMax : raw_m[PosW-1:0];
              mrem_next = mlen;
              if (d == 16'h0 || PosW'(d) > opos || mlen > room) begin
                phase_next = PH_DONE; st_next = StErr;
              end else begin
                eac_next = item.in_last;
                phase_next = PH_COPY;
              end
            end
          end
          default: begin
            phase_next = PH_DONE; st_next = StErr;
          end
        endcase
      end
    end
    work.copy_pending = (phase_next == PH_COPY);
    work.done_res = (phase_next == PH_DONE);
    work.status = (phase_next == PH_DONE) ? st_next : StRun;
    work.literal_found = fflag_next;
    work.literal_pos = fflag_next ? fpos_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TOKEN; nib <= '0; lrem <= '0; mrem <= '0; spos <= '0;
      opos <= '0; fpos <= '0; mdist <= '0; fflag <= 1'b0; eac <= 1'b0; st <= StRun;
    end else begin
      phase <= phase_next; nib <= nib_next; lrem <= lrem_next; mrem <= mrem_next;
      spos <= spos_next; opos <= opos_next; fpos <= fpos_next; mdist <= mdist_next;
      fflag <= fflag_next; eac <= eac_next; st <= st_next;
    end
  end

  `LZ4_ASSERT_IMP(a_copy_rem, clk, rst, phase == PH_COPY, mrem != '0)
  `LZ4_ASSERT_NEXT(a_done_holds, clk, rst, phase == PH_DONE, phase == PH_DONE && $stable(st))
  `LZ4_ASSERT_IMP(a_rd_wr, clk, rst, work.rd, work.wr)
endmodule

>>> hdl/lz4_out.sv
// ---------------------------------------------------------------------------
// LZ4 output stage
// Back part: writes history, reads copy bytes and queues the results.
// ---------------------------------------------------------------------------
`include "lz4_block_decompressor_top_assert.svh"
module lz4_out import lz4_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      take,
  input  work_t     work,
  output logic      full,
  output logic      empty,
  input  logic      pop,
  output out_item_t res
);
  logic [7:0] hist [0:(1<<HistAw)-1];
  logic [7:0] rdata;
  logic [HistAw-1:0] last_addr;
  logic [7:0] last_byte;
  logic s1_v, s1_rd, s1_fwd;
  logic [7:0] s1_lit;
  out_item_t s1_res;
  out_item_t q_in;
  out_item_t q [0:QDepth-1];
  logic [QAw-1:0] wp, rp;
  logic [QAw:0] cnt;
  logic [7:0] byte1;
  logic push_q, pop_q;

  // Copies may read the byte that the previous request is still writing; forward it.
  assign byte1 = !s1_rd ? s1_lit : (s1_fwd ? last_byte : rdata);

  always_ff @(posedge clk) begin
    if (work.rd) rdata <= hist[work.raddr];
    if (s1_v && s1_res.out_valid) hist[last_addr] <= byte1;
  end

  always_ff @(posedge clk) begin
    s1_rd <= work.rd;
    s1_lit <= work.lit;
    s1_fwd <= s1_v && s1_res.out_valid && work.raddr == last_addr;
    if (s1_v) last_byte <= byte1;
    if (take) begin
      s1_res.out_valid <= work.wr;
      s1_res.out_byte <= '0;
      s1_res.copy_pending <= work.copy_pending;
      s1_res.done_res <= work.done_res;
      s1_res.status <= work.status;
      s1_res.literal_found <= work.literal_found;
      s1_res.literal_pos <= work.literal_pos;
      last_addr <= work.addr;
    end
  end

  assign push_q = s1_v;
  assign pop_q = pop && !empty;
  assign empty = (cnt == '0);
  // One slot stays in reserve for the stage ahead of the queue.
  assign full = (cnt >= (QAw+1)'(QDepth - 1)) && !(pop_q) || cnt == (QAw+1)'(QDepth);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0; wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      s1_v <= take;
      if (push_q) wp <= wp + 1'b1;
      if (pop_q) rp <= rp + 1'b1;
      cnt <= cnt + (QAw+1)'(push_q) - (QAw+1)'(pop_q);
    end
  end

  always_comb begin
    q_in = s1_res;
    q_in.out_byte = s1_res.out_valid ? byte1 : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (push_q) begin
      q[wp] <= q_in;
    end
  end

  assign res = q[rp];

  `LZ4_ASSERT_IMP(a_no_ovf, clk, rst, push_q && !pop_q, cnt != (QAw+1)'(QDepth))
  `LZ4_ASSERT_IMP(a_no_udf, clk, rst, empty, !pop_q)
  `LZ4_ASSERT_NEXT(a_take_push, clk, rst, take, push_q)
endmodule

>>> hdl/lz4_block_decompressor_top.sv
// ---------------------------------------------------------------------------
// LZ4 block decompressor top level
// Decodes one LZ4 block, one compressed byte or copy tick per transaction.
// ---------------------------------------------------------------------------
// One request is taken per clock cycle while full is low; its result is
// registered, queued and shown on the result ports at the queue head. The
// parser keeps the whole sequence state and settles a request combinationally;
// the output stage reads the 64 KiB history memory through its registered read
// port and queues results, so full stays low while the consumer keeps up.
module lz4_block_decompressor_top import lz4_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  cfg_t cfg;
  work_t work;
  logic take;

  assign pready = 1'b1;
  assign take = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        RegSize:   cfg.expected_out_size <= pwdata[PosW-1:0];
        RegTgtEn:  cfg.target_enable <= pwdata[0];
        RegTgtPos: cfg.target_pos <= pwdata[24:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegSize:   prdata = {6'h0, cfg.expected_out_size};
      RegTgtEn:  prdata = {31'h0, cfg.target_enable};
      RegTgtPos: prdata = {7'h0, cfg.target_pos};
      default:   prdata = '0;
    endcase
  end

  lz4_parse u_parse (.clk(clk), .rst(rst), .cfg(cfg), .take(take), .item(in_item),
    .work(work));

  lz4_out u_out (.clk(clk), .rst(rst), .take(take), .work(work), .full(full),
    .empty(empty), .pop(pop), .res(out_item));
endmodule
